// File: sv/hcmt_pkg.sv
// ----------------------------------------------------------------------------
// hcmt_pkg
// Shared types and codes of the chained hash multiset table.
// ----------------------------------------------------------------------------
package hcmt_pkg;

    localparam int DEF_BUCKETS = 64;
    localparam int DEF_NODES   = 256;

    localparam logic [2:0] KIND_INS_UNIQ = 3'd0;
    localparam logic [2:0] KIND_INS_DUP  = 3'd1;
    localparam logic [2:0] KIND_DEL_ONE  = 3'd2;
    localparam logic [2:0] KIND_DEL_ALL  = 3'd3;
    localparam logic [2:0] KIND_QUERY    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [5:0]  bucket_index;
    } t_item;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] removed_count;
        logic [8:0] bucket_length;
        logic [8:0] total_entries;
        logic       is_empty;
    } t_result;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DIV, S_HRD, S_HWT, S_NWT, S_REL, S_IRD, S_IWT, S_DONE
    } t_state;

endpackage

// File: sv/hcmt_div.sv
// ----------------------------------------------------------------------------
// hcmt_div
// Bit-serial restoring remainder of a 32-bit key by the bucket count.
// ----------------------------------------------------------------------------
module hcmt_div import hcmt_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [31:0]                  i_dividend,
    input  logic [$clog2(BUCKETS+1)-1:0] i_divisor,
    output logic                         o_done,
    output logic [$clog2(BUCKETS)-1:0]   o_rem
);
    localparam int BW = $clog2(BUCKETS+1);
    localparam int HW = $clog2(BUCKETS);

    logic          r_run, r_done;
    logic [4:0]    r_cnt;
    logic [31:0]   r_dvd;
    logic [BW-1:0] r_rem;
    logic [BW:0]   w_t;

    assign w_t = {r_rem, r_dvd[31]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == 5'd31);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_run) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (w_t >= {1'b0, i_divisor}) r_rem <= BW'(w_t - {1'b0, i_divisor});
            else                          r_rem <= BW'(w_t);
        end
    end

    assign o_done = r_done;
    assign o_rem  = HW'(r_rem);
endmodule

// File: sv/hcmt_mem.sv
// ----------------------------------------------------------------------------
// hcmt_mem
// Bucket head memory and node memory (keys and links), registered read.
// ----------------------------------------------------------------------------
module hcmt_mem import hcmt_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int NODES   = DEF_NODES
) (
    input  logic                         i_clk,
    input  logic [$clog2(BUCKETS)-1:0]   i_head_raddr,
    output logic [$clog2(NODES+1)-1:0]   o_head_rdata,
    input  logic                         i_head_we,
    input  logic [$clog2(BUCKETS)-1:0]   i_head_waddr,
    input  logic [$clog2(NODES+1)-1:0]   i_head_wdata,
    input  logic [$clog2(NODES)-1:0]     i_node_raddr,
    output logic [31:0]                  o_node_rkey,
    output logic [$clog2(NODES+1)-1:0]   o_node_rlink,
    input  logic                         i_link_we,
    input  logic                         i_key_we,
    input  logic [$clog2(NODES)-1:0]     i_node_waddr,
    input  logic [$clog2(NODES+1)-1:0]   i_link_wdata,
    input  logic [31:0]                  i_key_wdata
);
    localparam int PW = $clog2(NODES+1);

    logic [PW-1:0] r_heads [BUCKETS];
    logic [PW-1:0] r_links [NODES];
    logic [31:0]   r_keys  [NODES];

    always_ff @(posedge i_clk) begin
        if (i_head_we) r_heads[i_head_waddr] <= i_head_wdata;
        o_head_rdata <= r_heads[i_head_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_link_we) r_links[i_node_waddr] <= i_link_wdata;
        o_node_rlink <= r_links[i_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_key_we) r_keys[i_node_waddr] <= i_key_wdata;
        o_node_rkey <= r_keys[i_node_raddr];
    end
endmodule

// File: sv/hcmt_ctrl.sv
// ----------------------------------------------------------------------------
// hcmt_ctrl
// Sequencer: clearing pass, chain walk, insert, unlink and release.
// ----------------------------------------------------------------------------
module hcmt_ctrl import hcmt_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int NODES   = DEF_NODES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  t_item                        i_item,
    output logic                         o_done,
    output t_result                      o_result,
    input  logic [$clog2(BUCKETS+1)-1:0] i_nbkt,
    output logic                         o_div_start,
    input  logic                         i_div_done,
    input  logic [$clog2(BUCKETS)-1:0]   i_div_rem,
    output logic [$clog2(BUCKETS)-1:0]   o_head_raddr,
    input  logic [$clog2(NODES+1)-1:0]   i_head_rdata,
    output logic                         o_head_we,
    output logic [$clog2(BUCKETS)-1:0]   o_head_waddr,
    output logic [$clog2(NODES+1)-1:0]   o_head_wdata,
    output logic [$clog2(NODES)-1:0]     o_node_raddr,
    input  logic [31:0]                  i_node_rkey,
    input  logic [$clog2(NODES+1)-1:0]   i_node_rlink,
    output logic                         o_link_we,
    output logic                         o_key_we,
    output logic [$clog2(NODES)-1:0]     o_node_waddr,
    output logic [$clog2(NODES+1)-1:0]   o_link_wdata,
    output logic [31:0]                  o_key_wdata
);
    localparam int PW   = $clog2(NODES+1);
    localparam int NA   = $clog2(NODES);
    localparam int HW   = $clog2(BUCKETS);
    localparam int CLRN = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam int CLW  = $clog2(CLRN);
    localparam logic [PW-1:0] NIL = PW'(NODES);

    t_state         r_state, n_state;
    logic [CLW-1:0] r_clr, n_clr;
    logic [2:0]     r_kind, n_kind;
    logic [31:0]    r_key, n_key;
    logic [HW-1:0]  r_b, n_b;
    logic [PW-1:0]  r_cur, n_cur, r_prev, n_prev, r_nxt, n_nxt, r_head, n_head;
    logic [PW-1:0]  r_free, n_free, r_count, n_count, r_removed, n_removed;
    logic [PW-1:0]  r_blen, n_blen;
    logic [1:0]     r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_free  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_free  <= n_free;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_key     <= n_key;
        r_b       <= n_b;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_nxt     <= n_nxt;
        r_head    <= n_head;
        r_removed <= n_removed;
        r_blen    <= n_blen;
        r_status  <= n_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_kind       = r_kind;
        n_key        = r_key;
        n_b          = r_b;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_nxt        = r_nxt;
        n_head       = r_head;
        n_free       = r_free;
        n_count      = r_count;
        n_removed    = r_removed;
        n_blen       = r_blen;
        n_status     = r_status;
        o_div_start  = 1'b0;
        o_head_raddr = r_b;
        o_head_we    = 1'b0;
        o_head_waddr = r_b;
        o_head_wdata = NIL;
        o_node_raddr = r_cur[NA-1:0];
        o_link_we    = 1'b0;
        o_key_we     = 1'b0;
        o_node_waddr = r_cur[NA-1:0];
        o_link_wdata = r_free;
        o_key_wdata  = r_key;
        unique case (r_state)
            S_CLR: begin
                o_head_we    = (32'(r_clr) < 32'(BUCKETS));
                o_head_waddr = r_clr[HW-1:0];
                o_link_we    = (32'(r_clr) < 32'(NODES));
                o_node_waddr = NA'(r_clr);
                o_link_wdata = PW'(32'(r_clr) + 32'd1);
                n_clr        = r_clr + CLW'(1);
                if (32'(r_clr) == CLRN - 1) n_state = S_IDLE;
            end
            S_IDLE: begin
                n_kind    = i_item.kind;
                n_key     = i_item.key;
                n_removed = '0;
                n_blen    = '0;
                n_status  = ST_OK;
                n_prev    = NIL;
                if (start) begin
                    priority if (i_item.kind == KIND_QUERY) begin
                        if (32'(i_item.bucket_index) >= 32'(i_nbkt)) begin
                            n_status = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_b     = HW'(i_item.bucket_index);
                            n_state = S_HRD;
                        end
                    end else if (i_item.kind == KIND_INS_UNIQ || i_item.kind == KIND_INS_DUP
                                 || i_item.kind == KIND_DEL_ONE
                                 || i_item.kind == KIND_DEL_ALL) begin
                        o_div_start = 1'b1;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_b     = i_div_rem;
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HWT;
            end
            S_HWT: begin
                n_head       = i_head_rdata;
                n_cur        = i_head_rdata;
                o_node_raddr = i_head_rdata[NA-1:0];
                priority if (r_kind == KIND_INS_DUP) begin
                    n_state = S_IRD;
                end else if (i_head_rdata == NIL) begin
                    if (r_kind == KIND_INS_UNIQ) n_state = S_IRD;
                    else begin
                        if (r_kind != KIND_QUERY) n_status = ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_NWT;
                end
            end
            S_NWT: begin
                n_nxt        = i_node_rlink;
                n_cur        = i_node_rlink;
                o_node_raddr = i_node_rlink[NA-1:0];
                priority if (r_kind == KIND_QUERY) begin
                    n_blen = r_blen + PW'(1);
                    if (i_node_rlink == NIL) n_state = S_DONE;
                end else if (r_kind == KIND_INS_UNIQ) begin
                    if (i_node_rkey == r_key) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end else if (i_node_rlink == NIL) begin
                        n_state = S_IRD;
                    end
                end else if (i_node_rkey == r_key) begin
                    n_cur = r_cur;
                    if (r_prev == NIL) begin
                        o_head_we    = 1'b1;
                        o_head_wdata = i_node_rlink;
                    end else begin
                        o_link_we    = 1'b1;
                        o_node_waddr = r_prev[NA-1:0];
                        o_link_wdata = i_node_rlink;
                    end
                    n_state = S_REL;
                end else begin
                    n_prev = r_cur;
                    if (i_node_rlink == NIL) begin
                        n_status = (r_removed == '0) ? ST_NOT_FOUND : ST_OK;
                        n_state  = S_DONE;
                    end
                end
            end
            S_REL: begin
                o_link_we    = 1'b1;
                o_link_wdata = r_free;
                n_free       = r_cur;
                if (r_count != '0) n_count = r_count - PW'(1);
                n_removed    = r_removed + PW'(1);
                n_status     = ST_OK;
                n_cur        = r_nxt;
                o_node_raddr = r_nxt[NA-1:0];
                if (r_kind == KIND_DEL_ONE || r_nxt == NIL) n_state = S_DONE;
                else n_state = S_NWT;
            end
            S_IRD: begin
                o_node_raddr = r_free[NA-1:0];
                if (r_free == NIL) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_IWT;
                end
            end
            S_IWT: begin
                o_node_waddr = r_free[NA-1:0];
                o_key_we     = 1'b1;
                o_link_we    = 1'b1;
                o_link_wdata = r_head;
                o_head_we    = 1'b1;
                o_head_wdata = r_free;
                n_free       = i_node_rlink;
                n_count      = r_count + PW'(1);
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_done                 = (r_state == S_DONE);
    assign o_result.status        = r_status;
    assign o_result.removed_count = 9'(r_removed);
    assign o_result.bucket_length = 9'(r_blen);
    assign o_result.total_entries = 9'(r_count);
    assign o_result.is_empty      = (r_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= NODES)
        else $error("entry count above pool size");
    a_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free == NIL) == (r_count == NIL))
        else $error("free list and entry count disagree");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted without going busy");
endmodule

// File: sv/chained_hash_multiset_table.sv
// ----------------------------------------------------------------------------
// chained_hash_multiset_table
// Separate-chaining hash multiset of 32-bit keys over a fixed node pool.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over max(BUCKETS, NODES) entries
// with busy high. A transaction is taken when start is high and busy is low;
// its one result appears on o_result for a single cycle with o_done high and
// cannot be held off. Steps per transaction: a key operation runs the
// bit-serial modulo (one key bit per cycle, then the done handoff) and the head
// read, then visits the chain one node at a time, spends one more step per
// removed node and two steps (S_IRD, S_IWT) on an insert, and ends in S_DONE
// before returning to idle; a length query skips the modulo.
// Chain walking is bounded by the single node memory read port.
module chained_hash_multiset_table import hcmt_pkg::*; #(
    parameter int BUCKETS = DEF_BUCKETS,
    parameter int NODES   = DEF_NODES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_item      i_item,
    output logic       o_done,
    output t_result    o_result,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data
);
    localparam int BW = $clog2(BUCKETS+1);
    localparam int HW = $clog2(BUCKETS);
    localparam int PW = $clog2(NODES+1);
    localparam int NA = $clog2(NODES);

    logic [6:0]    r_cfg;
    logic [BW-1:0] w_nbkt;
    logic          w_div_start, w_div_done;
    logic [HW-1:0] w_div_rem, w_head_raddr, w_head_waddr;
    logic [PW-1:0] w_head_rdata, w_head_wdata, w_node_rlink, w_link_wdata;
    logic          w_head_we, w_link_we, w_key_we;
    logic [NA-1:0] w_node_raddr, w_node_waddr;
    logic [31:0]   w_node_rkey, w_key_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 7'd64;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        priority if (r_cfg == 7'd0)              w_nbkt = BW'(1);
        else if (32'(r_cfg) > 32'(BUCKETS))      w_nbkt = BW'(BUCKETS);
        else                                     w_nbkt = BW'(r_cfg);
    end

    hcmt_div #(.BUCKETS(BUCKETS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (i_item.key),
        .i_divisor  (w_nbkt),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    hcmt_mem #(.BUCKETS(BUCKETS), .NODES(NODES)) u_mem (
        .i_clk        (i_clk),
        .i_head_raddr (w_head_raddr),
        .o_head_rdata (w_head_rdata),
        .i_head_we    (w_head_we),
        .i_head_waddr (w_head_waddr),
        .i_head_wdata (w_head_wdata),
        .i_node_raddr (w_node_raddr),
        .o_node_rkey  (w_node_rkey),
        .o_node_rlink (w_node_rlink),
        .i_link_we    (w_link_we),
        .i_key_we     (w_key_we),
        .i_node_waddr (w_node_waddr),
        .i_link_wdata (w_link_wdata),
        .i_key_wdata  (w_key_wdata)
    );

    hcmt_ctrl #(.BUCKETS(BUCKETS), .NODES(NODES)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_done       (o_done),
        .o_result     (o_result),
        .i_nbkt       (w_nbkt),
        .o_div_start  (w_div_start),
        .i_div_done   (w_div_done),
        .i_div_rem    (w_div_rem),
        .o_head_raddr (w_head_raddr),
        .i_head_rdata (w_head_rdata),
        .o_head_we    (w_head_we),
        .o_head_waddr (w_head_waddr),
        .o_head_wdata (w_head_wdata),
        .o_node_raddr (w_node_raddr),
        .i_node_rkey  (w_node_rkey),
        .i_node_rlink (w_node_rlink),
        .o_link_we    (w_link_we),
        .o_key_we     (w_key_we),
        .o_node_waddr (w_node_waddr),
        .o_link_wdata (w_link_wdata),
        .o_key_wdata  (w_key_wdata)
    );
endmodule

// File: tb/hcmt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hcmt_checker
// Watches the command, result and register ports of the chained hash table.
// Every accepted command updates a local copy of the table and queues the
// expected result; each strobed result is compared with the oldest one.
// ----------------------------------------------------------------------------
module hcmt_checker import hcmt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  t_item      i_item,
    input  logic       o_done,
    input  t_result    o_result,
    input  logic       i_cfg_we,
    input  logic [6:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam logic [8:0] NIL = 9'(DEF_NODES);

    logic [8:0]  chain_head [DEF_BUCKETS];
    logic [31:0] node_key   [DEF_NODES];
    logic [8:0]  node_next  [DEF_NODES];
    logic [8:0]  free_top;
    logic [8:0]  entry_total;
    logic [6:0]  modulus_reg;
    t_result     expected_results [$];

    assign o_pending = expected_results.size();

    task automatic clear_table();
        for (int i = 0; i < DEF_BUCKETS; i++) chain_head[i] = NIL;
        for (int i = 0; i < DEF_NODES; i++) begin
            node_key[i]  = '0;
            node_next[i] = 9'(i + 1);
        end
        free_top    = '0;
        entry_total = '0;
        modulus_reg = 7'd64;
    endtask

    function automatic t_result table_op(t_item it);
        t_result     res;
        int unsigned n;
        int unsigned b;
        logic [8:0]  cur;
        logic [8:0]  prev;
        logic [8:0]  nxt;
        logic        hit;
        int          removed;
        int          len;
        res     = '0;
        removed = 0;
        len     = 0;
        hit     = 1'b0;
        n = (modulus_reg == 0) ? 1 : (modulus_reg > DEF_BUCKETS) ? DEF_BUCKETS : modulus_reg;
        b = it.key % n;
        case (it.kind)
            KIND_INS_UNIQ, KIND_INS_DUP: begin
                if (it.kind == KIND_INS_UNIQ) begin
                    cur = chain_head[b];
                    while (cur != NIL && !hit) begin
                        if (node_key[cur] == it.key) hit = 1'b1;
                        else cur = node_next[cur];
                    end
                end
                if (hit) begin
                    res.status = ST_NOT_FOUND;
                end else if (free_top == NIL) begin
                    res.status = ST_FULL;
                end else begin
                    cur           = free_top;
                    free_top      = node_next[cur];
                    node_key[cur] = it.key;
                    node_next[cur] = chain_head[b];
                    chain_head[b] = cur;
                    entry_total++;
                end
            end
            KIND_DEL_ONE, KIND_DEL_ALL: begin
                prev = NIL;
                cur  = chain_head[b];
                while (cur != NIL) begin
                    nxt = node_next[cur];
                    if (node_key[cur] == it.key) begin
                        if (prev == NIL) chain_head[b] = nxt;
                        else node_next[prev] = nxt;
                        node_next[cur] = free_top;
                        free_top       = cur;
                        entry_total--;
                        removed++;
                        if (it.kind == KIND_DEL_ONE) break;
                    end else begin
                        prev = cur;
                    end
                    cur = nxt;
                end
                if (removed == 0) res.status = ST_NOT_FOUND;
            end
            KIND_QUERY: begin
                if (it.bucket_index >= n) begin
                    res.status = ST_RANGE;
                end else begin
                    cur = chain_head[it.bucket_index];
                    while (cur != NIL) begin
                        len++;
                        cur = node_next[cur];
                    end
                end
            end
            default: ;
        endcase
        res.removed_count = 9'(removed);
        res.bucket_length = 9'(len);
        res.total_entries = entry_total;
        res.is_empty      = (entry_total == 0);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        clear_table();
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    $error("result with no transaction outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_result.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_result.status);
                        o_fail_count++;
                    end
                    if (o_result.removed_count !== want.removed_count) begin
                        $error("removed_count: expected %0d, got %0d",
                               want.removed_count, o_result.removed_count);
                        o_fail_count++;
                    end
                    if (o_result.bucket_length !== want.bucket_length) begin
                        $error("bucket_length: expected %0d, got %0d",
                               want.bucket_length, o_result.bucket_length);
                        o_fail_count++;
                    end
                    if (o_result.total_entries !== want.total_entries) begin
                        $error("total_entries: expected %0d, got %0d",
                               want.total_entries, o_result.total_entries);
                        o_fail_count++;
                    end
                    if (o_result.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d", want.is_empty, o_result.is_empty);
                        o_fail_count++;
                    end
                end
            end
            if (start && !busy) expected_results.push_back(table_op(i_item));
            if (i_cfg_we) modulus_reg = i_cfg_data;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the chained hash multiset table: directed corner cases, a pool
// fill to overflow, then random key traffic under several bucket counts.
// ----------------------------------------------------------------------------
module tb;
    import hcmt_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       start      = 1'b0;
    logic       busy;
    t_item      i_item     = '0;
    logic       o_done;
    t_result    o_result;
    logic       i_cfg_we   = 1'b0;
    logic [6:0] i_cfg_data = '0;
    int         fail_count;
    int         pending;
    int         cycle_count = 0;
    int         gap_pct     = 0;
    logic [31:0] key_pool [16];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    chained_hash_multiset_table DUT (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_done, .o_result,
        .i_cfg_we, .i_cfg_data
    );

    hcmt_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_item, .o_done, .o_result,
        .i_cfg_we, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_op(logic [2:0] kind, logic [31:0] key, logic [5:0] idx);
        start  <= 1'b1;
        i_item <= '{kind: kind, key: key, bucket_index: idx};
        do @(posedge i_clk); while (busy);
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [6:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_op();
        int          r;
        logic [31:0] key;
        r   = $urandom_range(0, 99);
        key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 15)] : $urandom;
        if (r < 30)      send_op(KIND_INS_UNIQ, key, 6'($urandom));
        else if (r < 50) send_op(KIND_INS_DUP, key, 6'($urandom));
        else if (r < 65) send_op(KIND_DEL_ONE, key, 6'($urandom));
        else if (r < 75) send_op(KIND_DEL_ALL, key, 6'($urandom));
        else if (r < 96) send_op(KIND_QUERY, $urandom, 6'($urandom));
        else             send_op(3'($urandom_range(5, 7)), $urandom, 6'($urandom));
    endtask

    initial begin
        logic [6:0] settings [7];
        settings = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd100, 7'd13};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy);

        send_op(KIND_QUERY, 32'h0, 6'd0);
        send_op(KIND_QUERY, 32'h0, 6'd63);
        send_op(KIND_INS_UNIQ, 32'h0, 6'd0);
        send_op(KIND_INS_UNIQ, 32'hFFFF_FFFF, 6'd0);
        send_op(KIND_INS_UNIQ, 32'h0, 6'd0);
        send_op(KIND_INS_DUP, 32'h0, 6'd0);
        send_op(KIND_QUERY, 32'h0, 6'd0);
        send_op(KIND_QUERY, 32'h0, 6'd63);
        send_op(KIND_DEL_ONE, 32'd5, 6'd0);
        send_op(KIND_DEL_ALL, 32'd5, 6'd0);
        send_op(KIND_DEL_ALL, 32'h0, 6'd0);
        send_op(KIND_DEL_ONE, 32'hFFFF_FFFF, 6'd0);
        for (int k = 5; k < 8; k++) send_op(3'(k), 32'hFFFF_FFFF, 6'h3F);

        write_buckets(7'd1);
        send_op(KIND_QUERY, 32'h0, 6'd1);
        for (int k = 0; k < DEF_NODES; k++) send_op(KIND_INS_DUP, 32'd42, 6'd0);
        send_op(KIND_INS_DUP, 32'd42, 6'd0);
        send_op(KIND_INS_UNIQ, 32'd42, 6'd0);
        send_op(KIND_INS_UNIQ, 32'd7, 6'd0);
        send_op(KIND_QUERY, 32'h0, 6'd0);
        send_op(KIND_DEL_ONE, 32'd42, 6'd0);
        send_op(KIND_DEL_ALL, 32'd42, 6'd0);

        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int p = 0; p < 7; p++) begin
            write_buckets(settings[p]);
            for (int k = 0; k < 90; k++) begin
                gap_pct = (k < 30) ? 7 : (k < 60) ? 58 : 0;
                random_op();
                if (p == 3 && k == 45) drain();
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
